### rtl/asimd_pkg.sv
package asimd_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_MEMBER = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

endpackage

### rtl/array_set_insert_member_delete_top.sv
// Insert and unused op codes go from the idle state straight to the done state, which loads the result.
// Query and delete read the element store one entry per cycle through its single read port:
// a query stops at the first match or at the end of the set, and a delete then moves each later entry down one place.
// One transaction is in progress at a time; a new one is taken while a result still waits.
// The next transaction can be taken in the cycle after the result is loaded.
// Synchronous active-low reset empties the set; the element store itself is not cleared.
module array_set_insert_member_delete_top
    import asimd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic        o_full_error,
    output logic [7:0]  o_count
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SRCH  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [ADDR_W-1:0]   r_wr, n_wr;
    logic                r_pend, n_pend;
    logic [1:0]          r_op, n_op;
    logic [31:0]         r_value, n_value;
    logic                r_found, n_found;
    logic                r_full, n_full;
    logic                r_ovalid, n_ovalid;
    logic                r_ofound, n_ofound;
    logic                r_ofull, n_ofull;
    logic [7:0]          r_ocount, n_ocount;

    logic [31:0]         r_mem [CAPACITY];
    logic [31:0]         r_rd_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [31:0]         wr_data;
    logic                hit;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign hit = r_pend && (r_rd_data == r_value);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_wr     = r_wr;
        n_pend   = r_pend;
        n_op     = r_op;
        n_value  = r_value;
        n_found  = r_found;
        n_full   = r_full;
        n_ovalid = r_ovalid;
        n_ofound = r_ofound;
        n_ofull  = r_ofull;
        n_ocount = r_ocount;
        rd_en    = 1'b0;
        rd_addr  = r_idx[ADDR_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_count[ADDR_W-1:0];
        wr_data  = i_value;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_op;
                    n_value = i_value;
                    n_found = 1'b0;
                    n_full  = 1'b0;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                    case (i_op) inside
                        OP_INSERT: begin
                            if (r_count < CNT_W'(CAPACITY)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_full = 1'b1;
                            end
                        end
                        OP_MEMBER, OP_DELETE: begin
                            n_state = S_SRCH;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_pend  = 1'b0;
                    if (r_op == OP_DELETE) begin
                        n_wr    = ADDR_W'(r_idx - 1'b1);
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_idx < r_count) begin
                    rd_en  = 1'b1;
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wr;
                    wr_data = r_rd_data;
                    n_wr    = r_wr + 1'b1;
                end
                if (r_idx < r_count) begin
                    rd_en  = 1'b1;
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_found;
                    n_ofull  = r_full;
                    n_ocount = 8'(r_count);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_op     <= n_op;
        r_value  <= n_value;
        r_found  <= n_found;
        r_full   <= n_full;
        r_ofound <= n_ofound;
        r_ofull  <= n_ofull;
        r_ocount <= n_ocount;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_found      = r_ofound;
    assign o_full_error = r_ofull;
    assign o_count      = r_ocount;

endmodule

### rtl/asimd_chk.sv
module asimd_chk
    import asimd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_op,
    input logic [31:0] i_value,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic        o_full_error,
    input logic [7:0]  o_count
);

    // A refused insert never reports a match.
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_full_error && o_found))
        else $error("full_error and found both set");

    // A refused insert only happens with the store at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_error) |-> (o_count == 8'(CAPACITY)))
        else $error("full_error with store below capacity");

    // A refused insert leaves the count as it was, so the next result matches it for inserts.
    a_insert_full_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_full_error) ##1 (o_valid && o_full_error)
        |-> (o_count == 8'(CAPACITY)))
        else $error("count changed across refused inserts");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_found) && $stable(o_full_error)
        && $stable(o_count)))
        else $error("stalled result changed");

endmodule

bind array_set_insert_member_delete_top asimd_chk u_asimd_chk (.*);

### tb/tb_array_set_insert_member_delete_top.sv
module tb_array_set_insert_member_delete_top;
    import asimd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         SETTLE_CYCLES  = 150;

    typedef struct packed {
        logic       found;
        logic       full_error;
        logic [7:0] count;
    } set_response_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic        o_found;
    logic        o_full_error;
    logic [7:0]  o_count;

    set_response_t expected_responses[$];
    logic [31:0]   set_members[CAPACITY];
    int            member_count;
    int            burst_left;
    int            error_count;
    int            idle_cycles;

    array_set_insert_member_delete_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_full_error (o_full_error),
        .o_count      (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic set_response_t predict_set_response(input logic [1:0] op,
                                                           input logic [31:0] value);
        set_response_t resp;
        int            pos;
        int            k;
        resp = '0;
        pos  = -1;
        if (op == OP_INSERT) begin
            if (member_count >= CAPACITY) begin
                resp.full_error = 1'b1;
            end else begin
                set_members[member_count] = value;
                member_count++;
            end
        end else if (op == OP_MEMBER || op == OP_DELETE) begin
            for (k = 0; k < member_count; k++) begin
                if (pos < 0 && set_members[k] == value) begin
                    pos = k;
                end
            end
            if (pos >= 0) begin
                resp.found = 1'b1;
                if (op == OP_DELETE) begin
                    for (k = pos; k + 1 < member_count; k++) begin
                        set_members[k] = set_members[k + 1];
                    end
                    member_count--;
                end
            end
        end
        resp.count = member_count[7:0];
        return resp;
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned sel;
        logic [31:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 50 && member_count > 0) begin
            v = set_members[$urandom_range(0, member_count - 1)];
        end else if (sel < 65) begin
            v = $urandom_range(0, 7);
        end else if (sel < 72) begin
            case ($urandom_range(0, 3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    function automatic logic [1:0] pick_op(input int insert_pct, input int member_pct,
                                           input int delete_pct);
        int unsigned sel;
        logic [1:0]  op;
        sel = $urandom_range(0, 99);
        if (sel < insert_pct) begin
            op = OP_INSERT;
        end else if (sel < insert_pct + member_pct) begin
            op = OP_MEMBER;
        end else if (sel < insert_pct + member_pct + delete_pct) begin
            op = OP_DELETE;
        end else begin
            op = OP_UNUSED;
        end
        return op;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [31:0] value);
        int gap;
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_responses.push_back(predict_set_response(op, value));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_traffic(input int n, input int insert_pct,
                                      input int member_pct, input int delete_pct);
        logic [1:0] op;
        repeat (n) begin
            op = pick_op(insert_pct, member_pct, delete_pct);
            send_request(op, pick_value());
        end
    endtask

    task automatic test_empty_set();
        send_request(OP_MEMBER, 32'h0000_0000);
        send_request(OP_DELETE, 32'h8000_0000);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    task automatic test_extreme_values();
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_MEMBER, 32'h7FFF_FFFF);
        send_request(OP_MEMBER, 32'h0000_0001);
        send_request(OP_MEMBER, 32'h7FFF_FFFE);
        send_request(OP_UNUSED, 32'h1234_5678);
    endtask

    task automatic test_duplicates_and_shift();
        send_request(OP_INSERT, 32'd5);
        send_request(OP_INSERT, 32'd9);
        send_request(OP_INSERT, 32'd5);
        send_request(OP_DELETE, 32'd5);
        send_request(OP_MEMBER, 32'd5);
        send_request(OP_DELETE, 32'd5);
        send_request(OP_MEMBER, 32'd5);
        send_request(OP_DELETE, 32'h8000_0000);
        send_request(OP_DELETE, 32'd9);
        send_request(OP_DELETE, 32'h0000_0000);
        wait_for_results();
    endtask

    task automatic test_fill_to_full();
        run_random_traffic(300, 80, 10, 7);
        wait_for_results();
    endtask

    task automatic test_mixed_traffic();
        run_random_traffic(350, 40, 25, 30);
        wait_for_results();
    endtask

    task automatic test_drain_to_empty();
        run_random_traffic(300, 10, 20, 65);
        wait_for_results();
    endtask

    task automatic test_small_set();
        run_random_traffic(175, 35, 30, 30);
        wait_for_results();
    endtask

    initial begin
        int run_left;
        logic level;
        run_left = 0;
        level    = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                level = ~level;
                if (level) begin
                    run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 20);
                end else begin
                    run_left = $urandom_range(1, 24);
                end
            end
            run_left--;
            i_ready <= level;
        end
    end

    always @(posedge i_clk) begin
        set_response_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_responses.size() == 0) begin
                $error("unexpected result: found=%0d full_error=%0d count=%0d",
                       o_found, o_full_error, o_count);
                error_count++;
            end else begin
                want = expected_responses.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_found);
                    error_count++;
                end
                if (o_full_error !== want.full_error) begin
                    $error("full_error: expected %0d, actual %0d",
                           want.full_error, o_full_error);
                    error_count++;
                end
                if (o_count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, o_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_array_set_insert_member_delete_top failed");
            $finish;
        end
    end

    initial begin
        error_count  = 0;
        idle_cycles  = 0;
        member_count = 0;
        burst_left   = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op    <= OP_INSERT;
        i_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_set();
        test_extreme_values();
        test_duplicates_and_shift();
        test_fill_to_full();
        test_mixed_traffic();
        test_drain_to_empty();
        test_small_set();

        if (error_count == 0) begin
            $display("tb_array_set_insert_member_delete_top passed");
        end else begin
            $display("tb_array_set_insert_member_delete_top failed");
        end
        $finish;
    end

endmodule
